[design/gmwa_pkg.sv]
// ----------------------------------------------------------------------------
// gmwa_pkg: shared types and constants for greedy max weight assignment
// Sizes, field widths, input kind codes, sequencer states and the command
// struct between the sequencer and the best-entry unit.
// ----------------------------------------------------------------------------
package gmwa_pkg;

  localparam int MAX_VERTICES   = 32;
  localparam int WEIGHT_BITS    = 16;

  // fixed port widths
  localparam int FIELD_BITS     = 5;
  localparam int COUNT_BITS     = 6;
  localparam int IN_WEIGHT_BITS = 16;

  localparam int VCOUNT_RESET   = 32;

  // rows the 5-bit fields can reach
  localparam int FIELD_LIMIT    = 1 << FIELD_BITS;
  localparam int LIVE_MAX       = (MAX_VERTICES < FIELD_LIMIT) ? MAX_VERTICES : FIELD_LIMIT;
  localparam int IDX_BITS       = $clog2(LIVE_MAX);
  localparam int CNT_BITS       = $clog2(LIVE_MAX + 1);
  localparam int ADDR_BITS      = 2 * IDX_BITS;
  localparam int MEM_DEPTH      = 1 << ADDR_BITS;
  localparam int STORE_BITS     = (WEIGHT_BITS < IN_WEIGHT_BITS) ? WEIGHT_BITS : IN_WEIGHT_BITS;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_RUN     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic                clear;
    logic                issue;
    logic                free;
    logic [IDX_BITS-1:0] r;
    logic [IDX_BITS-1:0] c;
  } scan_cmd_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] r;
    logic [IDX_BITS-1:0] c;
  } best_t;

endpackage

[design/greedy_max_weight_assignment.sv]
// run: a run over n vertices scans the matrix in n rounds, each a scan, a drain and a commit,
//   then gives n result items, one a cycle when the output is not stalled
// throughput: one matrix read a cycle through the shared compare unit sets the scan time
// reset: a clearing pass over all 1024 entries zeroes the weight matrix, items wait meanwhile;
//   vertex_count resets to 32 and config writes are taken during the pass
// ----------------------------------------------------------------------------
// greedy_max_weight_assignment: greedy maximum weight row to column matching
// Holds a square weight matrix, runs greedy rounds on request and reports
// the column given to each row in row order.
// ----------------------------------------------------------------------------
module greedy_max_weight_assignment (
  input  logic                                clk,
  input  logic                                rst,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmwa_pkg::COUNT_BITS-1:0]     vertex_count,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [gmwa_pkg::FIELD_BITS-1:0]     row,
  input  logic [gmwa_pkg::FIELD_BITS-1:0]     col,
  input  logic [gmwa_pkg::IN_WEIGHT_BITS-1:0] weight,
  // result item channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gmwa_pkg::FIELD_BITS-1:0]     assigned_row,
  output logic [gmwa_pkg::FIELD_BITS-1:0]     assigned_col,
  output logic                                last
);

  logic [gmwa_pkg::COUNT_BITS-1:0] vcount;
  logic [gmwa_pkg::CNT_BITS-1:0]   n;

  logic                            we;
  logic [gmwa_pkg::ADDR_BITS-1:0]  waddr;
  logic [gmwa_pkg::STORE_BITS-1:0] wdata;
  logic [gmwa_pkg::ADDR_BITS-1:0]  raddr;
  logic [gmwa_pkg::STORE_BITS-1:0] rdata;
  gmwa_pkg::scan_cmd_t             cmd;
  gmwa_pkg::best_t                 best;

  // config register always accepts
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= gmwa_pkg::COUNT_BITS'(gmwa_pkg::VCOUNT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      vcount <= vertex_count;
    end
  end

  // vertex count in use saturates at the addressable matrix side
  always_comb begin
    if (vcount > gmwa_pkg::COUNT_BITS'(gmwa_pkg::LIVE_MAX)) begin
      n = gmwa_pkg::CNT_BITS'(gmwa_pkg::LIVE_MAX);
    end else begin
      n = gmwa_pkg::CNT_BITS'(vcount);
    end
  end

  // sequencer: clearing pass, writes, rounds, emission
  gmwa_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .row       (row),
    .col       (col),
    .weight    (weight),
    .n         (n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (assigned_row),
    .out_col   (assigned_col),
    .out_last  (last),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .cmd       (cmd),
    .best      (best)
  );

  // weight matrix, one entry read a cycle during a scan
  gmwa_wmem u_wmem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared compare unit keeps the best free entry of the round
  gmwa_best u_best (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .rdata (rdata),
    .best  (best)
  );

endmodule

[design/gmwa_wmem.sv]
// ----------------------------------------------------------------------------
// gmwa_wmem: weight matrix storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gmwa_wmem (
  input  logic                             clk,
  input  logic                             we,
  input  logic [gmwa_pkg::ADDR_BITS-1:0]   waddr,
  input  logic [gmwa_pkg::STORE_BITS-1:0]  wdata,
  input  logic [gmwa_pkg::ADDR_BITS-1:0]   raddr,
  output logic [gmwa_pkg::STORE_BITS-1:0]  rdata
);

  logic [gmwa_pkg::STORE_BITS-1:0] mem [gmwa_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/gmwa_best.sv]
// ----------------------------------------------------------------------------
// gmwa_best: shared compare unit
// Tracks the largest free entry seen in a round, first one wins on ties.
// ----------------------------------------------------------------------------
module gmwa_best (
  input  logic                            clk,
  input  logic                            rst,
  input  gmwa_pkg::scan_cmd_t             cmd,
  input  logic [gmwa_pkg::STORE_BITS-1:0] rdata,
  output gmwa_pkg::best_t                 best
);

  logic                            cand_valid;
  logic [gmwa_pkg::IDX_BITS-1:0]   cand_r;
  logic [gmwa_pkg::IDX_BITS-1:0]   cand_c;
  logic                            found;
  logic [gmwa_pkg::STORE_BITS-1:0] best_w;
  logic                            take;

  // candidate lines up with the registered read data
  assign take = cand_valid && (!found || (rdata > best_w));

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
      found      <= 1'b0;
    end else begin
      cand_valid <= cmd.issue && cmd.free;
      if (cmd.clear) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cmd.r;
    cand_c <= cmd.c;
    if (take && !cmd.clear) begin
      best_w <= rdata;
      best.r <= cand_r;
      best.c <= cand_c;
    end
  end

endmodule

[design/gmwa_seq.sv]
// ----------------------------------------------------------------------------
// gmwa_seq: sequencer
// Clearing pass, weight writes, round scans, commits and result emission.
// ----------------------------------------------------------------------------
module gmwa_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [gmwa_pkg::FIELD_BITS-1:0]     row,
  input  logic [gmwa_pkg::FIELD_BITS-1:0]     col,
  input  logic [gmwa_pkg::IN_WEIGHT_BITS-1:0] weight,
  input  logic [gmwa_pkg::CNT_BITS-1:0]       n,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gmwa_pkg::FIELD_BITS-1:0]     out_row,
  output logic [gmwa_pkg::FIELD_BITS-1:0]     out_col,
  output logic                                out_last,
  output logic                                we,
  output logic [gmwa_pkg::ADDR_BITS-1:0]      waddr,
  output logic [gmwa_pkg::STORE_BITS-1:0]     wdata,
  output logic [gmwa_pkg::ADDR_BITS-1:0]      raddr,
  output gmwa_pkg::scan_cmd_t                 cmd,
  input  gmwa_pkg::best_t                     best
);

  gmwa_pkg::seq_state_t state, state_next;

  logic [gmwa_pkg::ADDR_BITS-1:0] clr_addr;
  logic [gmwa_pkg::IDX_BITS-1:0]  scan_r;
  logic [gmwa_pkg::IDX_BITS-1:0]  scan_c;
  logic [gmwa_pkg::IDX_BITS-1:0]  round;
  logic [gmwa_pkg::IDX_BITS-1:0]  emit_r;
  logic [gmwa_pkg::LIVE_MAX-1:0]  row_blk;
  logic [gmwa_pkg::LIVE_MAX-1:0]  col_blk;
  logic [gmwa_pkg::IDX_BITS-1:0]  assign_col [gmwa_pkg::LIVE_MAX];

  logic [gmwa_pkg::IDX_BITS-1:0]  n_last;
  logic                           in_take;
  logic                           run_take;
  logic                           in_range;
  logic                           emit_load;
  logic                           scan_end;

  assign n_last   = gmwa_pkg::IDX_BITS'(n - gmwa_pkg::CNT_BITS'(1));
  assign in_stall = (state != gmwa_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign run_take = in_take && (kind == gmwa_pkg::KIND_RUN);
  assign in_range = ({1'b0, row} < (gmwa_pkg::FIELD_BITS+1)'(gmwa_pkg::LIVE_MAX)) &&
                    ({1'b0, col} < (gmwa_pkg::FIELD_BITS+1)'(gmwa_pkg::LIVE_MAX));
  assign emit_load = (state == gmwa_pkg::ST_EMIT) && (!out_valid || !out_stall);
  assign scan_end  = (scan_r == n_last) && (scan_c == n_last);

  // matrix write port: clearing pass or a write item
  always_comb begin
    if (state == gmwa_pkg::ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = in_take && (kind == gmwa_pkg::KIND_WRITE) && in_range;
      waddr = {row[gmwa_pkg::IDX_BITS-1:0], col[gmwa_pkg::IDX_BITS-1:0]};
      wdata = weight[gmwa_pkg::STORE_BITS-1:0];
    end
  end

  assign raddr     = {scan_r, scan_c};
  assign cmd.clear = (state == gmwa_pkg::ST_SCAN) && (scan_r == '0) && (scan_c == '0);
  assign cmd.issue = (state == gmwa_pkg::ST_SCAN);
  assign cmd.free  = !row_blk[scan_r] && !col_blk[scan_c];
  assign cmd.r     = scan_r;
  assign cmd.c     = scan_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmwa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gmwa_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = gmwa_pkg::ST_IDLE;
      end
      gmwa_pkg::ST_IDLE: begin
        if (run_take && (n != '0)) state_next = gmwa_pkg::ST_SCAN;
      end
      gmwa_pkg::ST_SCAN: begin
        if (scan_end) state_next = gmwa_pkg::ST_DRAIN;
      end
      gmwa_pkg::ST_DRAIN: begin
        state_next = gmwa_pkg::ST_COMMIT;
      end
      gmwa_pkg::ST_COMMIT: begin
        if (round == n_last) state_next = gmwa_pkg::ST_EMIT;
        else state_next = gmwa_pkg::ST_SCAN;
      end
      gmwa_pkg::ST_EMIT: begin
        if (emit_load && (emit_r == n_last)) state_next = gmwa_pkg::ST_IDLE;
      end
      default: state_next = gmwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      scan_r    <= '0;
      scan_c    <= '0;
      round     <= '0;
      emit_r    <= '0;
      out_valid <= 1'b0;
      row_blk   <= '0;
      col_blk   <= '0;
    end else begin
      if (state == gmwa_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (run_take) begin
        row_blk <= '0;
        col_blk <= '0;
        scan_r  <= '0;
        scan_c  <= '0;
        round   <= '0;
        emit_r  <= '0;
      end
      if (state == gmwa_pkg::ST_SCAN) begin
        if (scan_c == n_last) begin
          scan_c <= '0;
          if (scan_r == n_last) scan_r <= '0;
          else scan_r <= scan_r + 1'b1;
        end else begin
          scan_c <= scan_c + 1'b1;
        end
      end
      if (state == gmwa_pkg::ST_COMMIT) begin
        row_blk[best.r] <= 1'b1;
        col_blk[best.c] <= 1'b1;
        round           <= round + 1'b1;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
        emit_r    <= emit_r + 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == gmwa_pkg::ST_COMMIT) begin
      assign_col[best.r] <= best.c;
    end
    if (emit_load) begin
      out_row  <= gmwa_pkg::FIELD_BITS'(emit_r);
      out_col  <= gmwa_pkg::FIELD_BITS'(assign_col[emit_r]);
      out_last <= (emit_r == n_last);
    end
  end

endmodule
